### rtl/bado_pkg.sv
// shared types and mnemonic codes for the banked address and opcode decoder
package bado_pkg;

  typedef enum logic [5:0] {
    MN_COM    = 6'd0,
    MN_DDOUBL = 6'd1,
    MN_DOUBLE = 6'd2,
    MN_DTCB   = 6'd3,
    MN_DTCF   = 6'd4,
    MN_EXTEND = 6'd5,
    MN_INHINT = 6'd6,
    MN_NOOP   = 6'd7,
    MN_OVSK   = 6'd8,
    MN_RELINT = 6'd9,
    MN_RESUME = 6'd10,
    MN_RETURN = 6'd11,
    MN_TCAA   = 6'd12,
    MN_XLQ    = 6'd13,
    MN_XXALQ  = 6'd14,
    MN_ZL     = 6'd15,
    MN_TC     = 6'd16,
    MN_CCS    = 6'd17,
    MN_TCF    = 6'd18,
    MN_DAS    = 6'd19,
    MN_LXCH   = 6'd20,
    MN_INCR   = 6'd21,
    MN_ADS    = 6'd22,
    MN_CA     = 6'd23,
    MN_CS     = 6'd24,
    MN_INDEX  = 6'd25,
    MN_DXCH   = 6'd26,
    MN_TS     = 6'd27,
    MN_XCH    = 6'd28,
    MN_AD     = 6'd29,
    MN_MASK   = 6'd30,
    MN_DCOM   = 6'd31,
    MN_SQUARE = 6'd32,
    MN_ZQ     = 6'd33,
    MN_READ   = 6'd34,
    MN_WRITE  = 6'd35,
    MN_RAND   = 6'd36,
    MN_WAND   = 6'd37,
    MN_ROR    = 6'd38,
    MN_WOR    = 6'd39,
    MN_RXOR   = 6'd40,
    MN_EDRUPT = 6'd41,
    MN_DV     = 6'd42,
    MN_BZF    = 6'd43,
    MN_MSU    = 6'd44,
    MN_QXCH   = 6'd45,
    MN_AUG    = 6'd46,
    MN_DIM    = 6'd47,
    MN_DCA    = 6'd48,
    MN_DCS    = 6'd49,
    MN_SU     = 6'd50,
    MN_BZMF   = 6'd51,
    MN_MP     = 6'd52
  } mnemonic_t;

  typedef enum logic [1:0] {
    PFX_NONE  = 2'd0,
    PFX_SUBST = 2'd1,
    PFX_INDEX = 2'd2
  } prefix_t;

  localparam logic [2:0] OPC0 = 3'd0;
  localparam logic [2:0] OPC1 = 3'd1;
  localparam logic [2:0] OPC2 = 3'd2;
  localparam logic [2:0] OPC3 = 3'd3;
  localparam logic [2:0] OPC4 = 3'd4;
  localparam logic [2:0] OPC5 = 3'd5;
  localparam logic [2:0] OPC6 = 3'd6;
  localparam logic [2:0] OPC7 = 3'd7;

  localparam logic [1:0] QC0 = 2'd0;
  localparam logic [1:0] QC1 = 2'd1;
  localparam logic [1:0] QC2 = 2'd2;
  localparam logic [1:0] QC3 = 2'd3;

  typedef struct packed {
    logic        fixed;
    logic [5:0]  bank;
    logic [9:0]  offset;
  } loc_t;

  typedef struct packed {
    prefix_t     prefix;
    mnemonic_t   mnemonic;
    logic [11:0] operand;
    logic        has_operand;
  } dec_t;

endpackage

### rtl/bado_addr.sv
// address region resolver: bank and offset from program address
module bado_addr (
  input  logic [11:0]   z_address,
  input  logic [14:0]   bank_register,
  input  logic          superbank_bit,
  output bado_pkg::loc_t loc
);
  import bado_pkg::*;

  localparam logic [11:0] ERASABLE_FIXED_END = 12'o1400;
  localparam logic [11:0] SWITCHED_E_END     = 12'o2000;
  localparam logic [11:0] FIXED_FIXED_START  = 12'o4000;
  localparam logic [4:0]  SUPERBANK_FIRST    = 5'o30;
  localparam logic [5:0]  SUPERBANK_BUMP     = 6'o10;

  logic [4:0] fbank;

  assign fbank = bank_register[14:10];

  always_comb begin
    priority if (z_address < ERASABLE_FIXED_END) begin
      loc.fixed  = 1'b0;
      loc.bank   = {4'd0, z_address[9:8]};
      loc.offset = {2'd0, z_address[7:0]};
    end else if (z_address >= FIXED_FIXED_START) begin
      loc.fixed  = 1'b1;
      loc.bank   = 6'd2 + {5'd0, z_address[10]};
      loc.offset = z_address[9:0];
    end else if (z_address < SWITCHED_E_END) begin
      loc.fixed  = 1'b0;
      loc.bank   = {3'd0, bank_register[2:0]};
      loc.offset = {2'd0, z_address[7:0]};
    end else begin
      loc.fixed  = 1'b1;
      if (superbank_bit && fbank >= SUPERBANK_FIRST) begin
        loc.bank = {1'b0, fbank} + SUPERBANK_BUMP;
      end else begin
        loc.bank = {1'b0, fbank};
      end
      loc.offset = z_address[9:0];
    end
  end

endmodule

### rtl/bado_decode.sv
// effective word former and instruction decoder
module bado_decode (
  input  logic [11:0]    z_address,
  input  logic [14:0]    bank_register,
  input  logic [14:0]    memory_word,
  input  logic           extracode,
  input  logic           substitute,
  input  logic [14:0]    index_value,
  input  logic           fixed,
  output bado_pkg::dec_t dec
);
  import bado_pkg::*;

  localparam logic [16:0] W_COM    = 17'o040000;
  localparam logic [16:0] W_DDOUBL = 17'o020001;
  localparam logic [16:0] W_DOUBLE = 17'o060000;
  localparam logic [16:0] W_DTCB   = 17'o052006;
  localparam logic [16:0] W_DTCF   = 17'o052005;
  localparam logic [16:0] W_EXTEND = 17'o000006;
  localparam logic [16:0] W_INHINT = 17'o000004;
  localparam logic [16:0] W_ENOOP  = 17'o030000;
  localparam logic [16:0] W_OVSK   = 17'o054000;
  localparam logic [16:0] W_RELINT = 17'o000003;
  localparam logic [16:0] W_RESUME = 17'o050017;
  localparam logic [16:0] W_RETURN = 17'o000002;
  localparam logic [16:0] W_TCAA   = 17'o054005;
  localparam logic [16:0] W_XLQ    = 17'o000001;
  localparam logic [16:0] W_XXALQ  = 17'o000000;
  localparam logic [16:0] W_ZL     = 17'o022007;
  localparam logic [16:0] W_DCOM   = 17'o040001;
  localparam logic [16:0] W_SQUARE = 17'o070000;
  localparam logic [16:0] W_ZQ     = 17'o022007;
  localparam logic [16:0] W_NO_NOOP = 17'd10000;

  logic [16:0] v;
  prefix_t     pfx;
  logic [11:0] vm1;
  logic [11:0] op12;
  logic [11:0] op10;
  logic [11:0] op9;
  logic [1:0]  sel;
  logic [2:0]  opc;
  logic [16:0] z_next_word;
  logic        fixed_noop;

  always_comb begin
    priority if (substitute) begin
      v   = {2'd0, bank_register};
      pfx = PFX_SUBST;
    end else if (index_value != '0) begin
      if (!index_value[14]) begin
        v = {2'd0, memory_word} + {2'd0, index_value};
      end else begin
        v = {2'd0, memory_word} - {2'd0, ~index_value};
      end
      pfx = PFX_INDEX;
    end else begin
      v   = {2'd0, memory_word};
      pfx = PFX_NONE;
    end
  end

  assign vm1         = v[11:0] - 12'd1;
  assign op12        = v[11:0];
  assign op10        = {2'd0, v[9:0]};
  assign op9         = {3'd0, v[8:0]};
  assign sel         = v[11:10];
  assign opc         = v[14:12];
  assign z_next_word = {5'd0, z_address} + 17'd1;
  assign fixed_noop  = fixed && v == z_next_word && v != W_NO_NOOP;

  always_comb begin
    dec.prefix      = pfx;
    dec.mnemonic    = MN_XXALQ;
    dec.operand     = '0;
    dec.has_operand = 1'b0;
    if (!extracode) begin
      priority if (v == W_COM)    dec.mnemonic = MN_COM;
      else if (v == W_DDOUBL)     dec.mnemonic = MN_DDOUBL;
      else if (v == W_DOUBLE)     dec.mnemonic = MN_DOUBLE;
      else if (v == W_DTCB)       dec.mnemonic = MN_DTCB;
      else if (v == W_DTCF)       dec.mnemonic = MN_DTCF;
      else if (v == W_EXTEND)     dec.mnemonic = MN_EXTEND;
      else if (v == W_INHINT)     dec.mnemonic = MN_INHINT;
      else if (fixed_noop)        dec.mnemonic = MN_NOOP;
      else if (!fixed && v == W_ENOOP) dec.mnemonic = MN_NOOP;
      else if (v == W_OVSK)       dec.mnemonic = MN_OVSK;
      else if (v == W_RELINT)     dec.mnemonic = MN_RELINT;
      else if (v == W_RESUME)     dec.mnemonic = MN_RESUME;
      else if (v == W_RETURN)     dec.mnemonic = MN_RETURN;
      else if (v == W_TCAA)       dec.mnemonic = MN_TCAA;
      else if (v == W_XLQ)        dec.mnemonic = MN_XLQ;
      else if (v == W_XXALQ)      dec.mnemonic = MN_XXALQ;
      else if (v == W_ZL)         dec.mnemonic = MN_ZL;
      else begin
        dec.has_operand = 1'b1;
        unique case (opc)
          OPC0: begin
            dec.mnemonic = MN_TC;
            dec.operand  = op12;
          end
          OPC1: begin
            if (sel == QC0) begin
              dec.mnemonic = MN_CCS;
              dec.operand  = op10;
            end else begin
              dec.mnemonic = MN_TCF;
              dec.operand  = op12;
            end
          end
          OPC2: begin
            unique case (sel)
              QC0: begin
                dec.mnemonic = MN_DAS;
                dec.operand  = {2'd0, vm1[9:0]};
              end
              QC1: begin
                dec.mnemonic = MN_LXCH;
                dec.operand  = op10;
              end
              QC2: begin
                dec.mnemonic = MN_INCR;
                dec.operand  = op10;
              end
              QC3: begin
                dec.mnemonic = MN_ADS;
                dec.operand  = op10;
              end
              default: ;
            endcase
          end
          OPC3: begin
            dec.mnemonic = MN_CA;
            dec.operand  = op12;
          end
          OPC4: begin
            dec.mnemonic = MN_CS;
            dec.operand  = op12;
          end
          OPC5: begin
            unique case (sel)
              QC0: begin
                dec.mnemonic = MN_INDEX;
                dec.operand  = op10;
              end
              QC1: begin
                dec.mnemonic = MN_DXCH;
                dec.operand  = {2'd0, vm1[9:0]};
              end
              QC2: begin
                dec.mnemonic = MN_TS;
                dec.operand  = op10;
              end
              QC3: begin
                dec.mnemonic = MN_XCH;
                dec.operand  = op10;
              end
              default: ;
            endcase
          end
          OPC6: begin
            dec.mnemonic = MN_AD;
            dec.operand  = op12;
          end
          OPC7: begin
            dec.mnemonic = MN_MASK;
            dec.operand  = op12;
          end
          default: ;
        endcase
      end
    end else begin
      priority if (v == W_DCOM)   dec.mnemonic = MN_DCOM;
      else if (v == W_RESUME)     dec.mnemonic = MN_RESUME;
      else if (v == W_SQUARE)     dec.mnemonic = MN_SQUARE;
      else if (v == W_ZQ)         dec.mnemonic = MN_ZQ;
      else begin
        dec.has_operand = 1'b1;
        unique case (opc)
          OPC0: begin
            dec.mnemonic = mnemonic_t'(6'(MN_READ) + {3'd0, v[11:9]});
            dec.operand  = op9;
          end
          OPC1: begin
            if (sel == QC0) begin
              dec.mnemonic = MN_DV;
              dec.operand  = op10;
            end else begin
              dec.mnemonic = MN_BZF;
              dec.operand  = op12;
            end
          end
          OPC2: begin
            dec.mnemonic = mnemonic_t'(6'(MN_MSU) + {4'd0, sel});
            dec.operand  = op10;
          end
          OPC3: begin
            dec.mnemonic = MN_DCA;
            dec.operand  = vm1;
          end
          OPC4: begin
            dec.mnemonic = MN_DCS;
            dec.operand  = vm1;
          end
          OPC5: begin
            dec.mnemonic = MN_INDEX;
            dec.operand  = op12;
          end
          OPC6: begin
            if (sel == QC0) begin
              dec.mnemonic = MN_SU;
              dec.operand  = op10;
            end else begin
              dec.mnemonic = MN_BZMF;
              dec.operand  = op12;
            end
          end
          OPC7: begin
            dec.mnemonic = MN_MP;
            dec.operand  = op12;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/banked_address_and_opcode_decoder.sv
// top level: input register, address resolve and decode, result register
//
// One input word carries a program address, the bank register, the
// superbank bit, the fetched word, and the extracode, substitute and
// index values. One result word comes back per input word: the memory
// region, bank and offset, the fetched word, and the decoded mnemonic
// with its prefix and operand.
// Both channels use valid/ready; a word moves when valid and ready are
// high at the same rising edge.
// An accepted word sits in the input register while the decode logic
// feeds the result register. Throughput is one word per cycle while
// out_ready stays high, set by the two register stages that each take
// a new word whenever the next stage frees up.
// While the receiver stalls, the result register holds and the input
// register takes one more word if it is empty, then in_ready drops.
// A synchronous reset empties both stages; there is no other state.
module banked_address_and_opcode_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] z_address,
  input  logic [14:0] bank_register,
  input  logic        superbank_bit,
  input  logic [14:0] memory_word,
  input  logic        extracode,
  input  logic        substitute,
  input  logic [14:0] index_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        location_is_fixed,
  output logic [5:0]  bank,
  output logic [9:0]  offset,
  output logic [14:0] shown_word,
  output logic [1:0]  prefix,
  output logic [5:0]  mnemonic,
  output logic [11:0] operand,
  output logic        has_operand
);
  import bado_pkg::*;

  logic        s1_valid;
  logic        s1_ready;
  logic        out_load;
  logic [11:0] s1_z;
  logic [14:0] s1_bb;
  logic        s1_sb;
  logic [14:0] s1_word;
  logic        s1_xc;
  logic        s1_sub;
  logic [14:0] s1_idx;
  loc_t        loc;
  dec_t        dec;

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;
  assign out_load = s1_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_z    <= z_address;
      s1_bb   <= bank_register;
      s1_sb   <= superbank_bit;
      s1_word <= memory_word;
      s1_xc   <= extracode;
      s1_sub  <= substitute;
      s1_idx  <= index_value;
    end
  end

  bado_addr u_addr (
    .z_address     (s1_z),
    .bank_register (s1_bb),
    .superbank_bit (s1_sb),
    .loc           (loc)
  );

  bado_decode u_decode (
    .z_address     (s1_z),
    .bank_register (s1_bb),
    .memory_word   (s1_word),
    .extracode     (s1_xc),
    .substitute    (s1_sub),
    .index_value   (s1_idx),
    .fixed         (loc.fixed),
    .dec           (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      location_is_fixed <= loc.fixed;
      bank              <= loc.bank;
      offset            <= loc.offset;
      shown_word        <= s1_word;
      prefix            <= dec.prefix;
      mnemonic          <= dec.mnemonic;
      operand           <= dec.operand;
      has_operand       <= dec.has_operand;
    end
  end

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted word did not reach the input register");

  a_no_operand_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_operand |-> operand == 12'd0)
    else $error("operandless mnemonic carries an operand");

  a_prefix_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> prefix != 2'd3)
    else $error("illegal prefix code");

  a_bank_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bank <= 6'd39)
    else $error("bank out of range");

  a_erasable_bank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !location_is_fixed |-> bank < 6'd8 && offset < 10'd256)
    else $error("erasable location out of range");

endmodule

### tb/tb_banked_address_and_opcode_decoder.sv
// self-checking testbench for the banked address and opcode decoder
module tb_banked_address_and_opcode_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import bado_pkg::*;

  localparam logic [11:0] ADDR_SWITCHED_E = 12'o1400;
  localparam logic [11:0] ADDR_SWITCHED_F = 12'o2000;
  localparam logic [11:0] ADDR_FIXED_FIXED = 12'o4000;
  localparam logic [5:0]  BANK_SUPER_LOW = 6'o30;
  localparam logic [5:0]  BANK_SUPER_BUMP = 6'o10;

  localparam logic [14:0] WORD_COM     = 15'o40000;
  localparam logic [14:0] WORD_DDOUBL  = 15'o20001;
  localparam logic [14:0] WORD_DOUBLE  = 15'o60000;
  localparam logic [14:0] WORD_DTCB    = 15'o52006;
  localparam logic [14:0] WORD_DTCF    = 15'o52005;
  localparam logic [14:0] WORD_EXTEND  = 15'o6;
  localparam logic [14:0] WORD_INHINT  = 15'o4;
  localparam logic [14:0] WORD_NOOP_E  = 15'o30000;
  localparam logic [14:0] WORD_OVSK    = 15'o54000;
  localparam logic [14:0] WORD_RELINT  = 15'o3;
  localparam logic [14:0] WORD_RESUME  = 15'o50017;
  localparam logic [14:0] WORD_RETURN  = 15'o2;
  localparam logic [14:0] WORD_TCAA    = 15'o54005;
  localparam logic [14:0] WORD_XLQ     = 15'o1;
  localparam logic [14:0] WORD_XXALQ   = 15'o0;
  localparam logic [14:0] WORD_ZL      = 15'o22007;
  localparam logic [14:0] WORD_DCOM    = 15'o40001;
  localparam logic [14:0] WORD_SQUARE  = 15'o70000;
  localparam logic [14:0] WORD_ZQ      = 15'o22007;
  localparam logic [14:0] WORD_NO_NOOP = 15'd10000;

  localparam int RANDOM_WORDS = 1500;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [11:0] z;
    logic [14:0] bb;
    logic        sb;
    logic [14:0] word;
    logic        xc;
    logic        sub;
    logic [14:0] idx;
  } fetch_t;

  typedef struct packed {
    logic        fixed;
    logic [5:0]  bank;
    logic [9:0]  offset;
    logic [14:0] word;
    prefix_t     pfx;
    mnemonic_t   mn;
    logic [11:0] operand;
    logic        has_op;
  } decode_t;

  typedef struct {
    fetch_t  stim;
    bit      typed;
    decode_t want;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] z_address = '0;
  logic [14:0] bank_register = '0;
  logic        superbank_bit = 1'b0;
  logic [14:0] memory_word = '0;
  logic        extracode = 1'b0;
  logic        substitute = 1'b0;
  logic [14:0] index_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        location_is_fixed;
  logic [5:0]  bank;
  logic [9:0]  offset;
  logic [14:0] shown_word;
  logic [1:0]  prefix;
  logic [5:0]  mnemonic;
  logic [11:0] operand;
  logic        has_operand;

  decode_t pending_decodes[$];
  vector_t stim_table[$];
  int      mismatches = 0;
  int      words_sent = 0;
  int      burst_left = 0;

  banked_address_and_opcode_decoder u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .z_address         (z_address),
    .bank_register     (bank_register),
    .superbank_bit     (superbank_bit),
    .memory_word       (memory_word),
    .extracode         (extracode),
    .substitute        (substitute),
    .index_value       (index_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .location_is_fixed (location_is_fixed),
    .bank              (bank),
    .offset            (offset),
    .shown_word        (shown_word),
    .prefix            (prefix),
    .mnemonic          (mnemonic),
    .operand           (operand),
    .has_operand       (has_operand)
  );

  always #4 clk = ~clk;

  function automatic fetch_t mk_fetch(logic [11:0] z, logic [14:0] bb, logic sb,
                                      logic [14:0] word, logic xc, logic sub,
                                      logic [14:0] idx);
    fetch_t f;
    f.z = z;
    f.bb = bb;
    f.sb = sb;
    f.word = word;
    f.xc = xc;
    f.sub = sub;
    f.idx = idx;
    return f;
  endfunction

  function automatic decode_t mk_decode(logic fixed, logic [5:0] bnk, logic [9:0] ofs,
                                        logic [14:0] word, prefix_t pfx, mnemonic_t mn,
                                        logic [11:0] opnd, logic has_op);
    decode_t d;
    d.fixed = fixed;
    d.bank = bnk;
    d.offset = ofs;
    d.word = word;
    d.pfx = pfx;
    d.mn = mn;
    d.operand = opnd;
    d.has_op = has_op;
    return d;
  endfunction

  function automatic decode_t resolve_and_decode(fetch_t f);
    decode_t     r;
    logic [16:0] v;
    logic [16:0] vm1;
    logic [1:0]  sel;
    logic [2:0]  grp;
    r = '0;
    r.word = f.word;
    if (f.z < ADDR_SWITCHED_E) begin
      r.fixed = 1'b0;
      r.bank = {2'b0, f.z[11:8]};
      r.offset = {2'b0, f.z[7:0]};
    end else if (f.z >= ADDR_FIXED_FIXED) begin
      r.fixed = 1'b1;
      r.bank = 6'(2 + ((f.z - ADDR_FIXED_FIXED) >> 10));
      r.offset = f.z[9:0];
    end else if (f.z < ADDR_SWITCHED_F) begin
      r.fixed = 1'b0;
      r.bank = {3'b0, f.bb[2:0]};
      r.offset = {2'b0, f.z[7:0]};
    end else begin
      r.fixed = 1'b1;
      r.bank = {1'b0, f.bb[14:10]};
      if (r.bank >= BANK_SUPER_LOW && f.sb) r.bank = r.bank + BANK_SUPER_BUMP;
      r.offset = f.z[9:0];
    end

    v = {2'b0, f.word};
    r.pfx = PFX_NONE;
    if (f.sub) begin
      v = {2'b0, f.bb};
      r.pfx = PFX_SUBST;
    end else if (f.idx != '0) begin
      if (!f.idx[14]) v = v + {2'b0, f.idx};
      else v = v - {2'b0, ~f.idx};
      r.pfx = PFX_INDEX;
    end

    vm1 = v - 17'd1;
    sel = v[11:10];
    grp = v[14:12];
    r.operand = '0;
    r.has_op = 1'b0;
    if (!f.xc) begin
      if (v == WORD_COM) r.mn = MN_COM;
      else if (v == WORD_DDOUBL) r.mn = MN_DDOUBL;
      else if (v == WORD_DOUBLE) r.mn = MN_DOUBLE;
      else if (v == WORD_DTCB) r.mn = MN_DTCB;
      else if (v == WORD_DTCF) r.mn = MN_DTCF;
      else if (v == WORD_EXTEND) r.mn = MN_EXTEND;
      else if (v == WORD_INHINT) r.mn = MN_INHINT;
      else if (r.fixed && v == {5'b0, f.z} + 17'd1 && v != WORD_NO_NOOP) r.mn = MN_NOOP;
      else if (!r.fixed && v == WORD_NOOP_E) r.mn = MN_NOOP;
      else if (v == WORD_OVSK) r.mn = MN_OVSK;
      else if (v == WORD_RELINT) r.mn = MN_RELINT;
      else if (v == WORD_RESUME) r.mn = MN_RESUME;
      else if (v == WORD_RETURN) r.mn = MN_RETURN;
      else if (v == WORD_TCAA) r.mn = MN_TCAA;
      else if (v == WORD_XLQ) r.mn = MN_XLQ;
      else if (v == WORD_XXALQ) r.mn = MN_XXALQ;
      else if (v == WORD_ZL) r.mn = MN_ZL;
      else begin
        r.has_op = 1'b1;
        r.operand = v[11:0];
        case (grp)
          OPC0: r.mn = MN_TC;
          OPC1: begin
            r.mn = (sel == QC0) ? MN_CCS : MN_TCF;
            if (sel == QC0) r.operand = {2'b0, v[9:0]};
          end
          OPC2: begin
            r.operand = {2'b0, v[9:0]};
            case (sel)
              QC0: begin
                r.mn = MN_DAS;
                r.operand = {2'b0, vm1[9:0]};
              end
              QC1: r.mn = MN_LXCH;
              QC2: r.mn = MN_INCR;
              default: r.mn = MN_ADS;
            endcase
          end
          OPC3: r.mn = MN_CA;
          OPC4: r.mn = MN_CS;
          OPC5: begin
            r.operand = {2'b0, v[9:0]};
            case (sel)
              QC0: r.mn = MN_INDEX;
              QC1: begin
                r.mn = MN_DXCH;
                r.operand = {2'b0, vm1[9:0]};
              end
              QC2: r.mn = MN_TS;
              default: r.mn = MN_XCH;
            endcase
          end
          OPC6: r.mn = MN_AD;
          default: r.mn = MN_MASK;
        endcase
      end
    end else begin
      if (v == WORD_DCOM) r.mn = MN_DCOM;
      else if (v == WORD_RESUME) r.mn = MN_RESUME;
      else if (v == WORD_SQUARE) r.mn = MN_SQUARE;
      else if (v == WORD_ZQ) r.mn = MN_ZQ;
      else begin
        r.has_op = 1'b1;
        r.operand = v[11:0];
        case (grp)
          OPC0: begin
            r.mn = mnemonic_t'(int'(MN_READ) + int'(v[11:9]));
            r.operand = {3'b0, v[8:0]};
          end
          OPC1: begin
            r.mn = (sel == QC0) ? MN_DV : MN_BZF;
            if (sel == QC0) r.operand = {2'b0, v[9:0]};
          end
          OPC2: begin
            r.mn = mnemonic_t'(int'(MN_MSU) + int'(sel));
            r.operand = {2'b0, v[9:0]};
          end
          OPC3: begin
            r.mn = MN_DCA;
            r.operand = vm1[11:0];
          end
          OPC4: begin
            r.mn = MN_DCS;
            r.operand = vm1[11:0];
          end
          OPC5: r.mn = MN_INDEX;
          OPC6: begin
            r.mn = (sel == QC0) ? MN_SU : MN_BZMF;
            if (sel == QC0) r.operand = {2'b0, v[9:0]};
          end
          default: r.mn = MN_MP;
        endcase
      end
    end
    return r;
  endfunction

  function automatic logic [14:0] code_word(int k);
    case (k)
      0: return WORD_COM;
      1: return WORD_DDOUBL;
      2: return WORD_DOUBLE;
      3: return WORD_DTCB;
      4: return WORD_DTCF;
      5: return WORD_EXTEND;
      6: return WORD_INHINT;
      7: return WORD_NOOP_E;
      8: return WORD_OVSK;
      9: return WORD_RELINT;
      10: return WORD_RESUME;
      11: return WORD_RETURN;
      12: return WORD_TCAA;
      13: return WORD_XLQ;
      14: return WORD_XXALQ;
      15: return WORD_ZL;
      16: return WORD_DCOM;
      17: return WORD_SQUARE;
      default: return WORD_NO_NOOP;
    endcase
  endfunction

  function automatic fetch_t random_fetch();
    fetch_t f;
    f.z = 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0: f.z = ADDR_SWITCHED_E - 12'd1;
        1: f.z = ADDR_SWITCHED_E;
        2: f.z = ADDR_SWITCHED_F - 12'd1;
        3: f.z = ADDR_SWITCHED_F;
        4: f.z = ADDR_FIXED_FIXED - 12'd1;
        default: f.z = ADDR_FIXED_FIXED;
      endcase
    end
    f.bb = 15'($urandom_range(0, 32767));
    if ($urandom_range(0, 3) == 0) f.bb[14:13] = 2'b11;
    f.sb = 1'($urandom_range(0, 1));
    f.xc = 1'($urandom_range(0, 1));
    f.sub = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: f.idx = '0;
      4: f.idx = 15'h7FFF;
      5: f.idx = 15'h7FFF - 15'($urandom_range(0, 15));
      default: f.idx = 15'($urandom_range(1, 32767));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: f.word = code_word($urandom_range(0, 18));
      3: f.word = {3'b0, f.z} + 15'd1;
      default: f.word = 15'($urandom_range(0, 32767));
    endcase
    if (f.sub && $urandom_range(0, 1) == 1) f.bb = code_word($urandom_range(0, 18));
    return f;
  endfunction

  task automatic add_vector(fetch_t stim, bit typed, decode_t want);
    vector_t row;
    row.stim = stim;
    row.typed = typed;
    row.want = want;
    stim_table.push_back(row);
  endtask

  task automatic offer_word(fetch_t f, decode_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    z_address <= f.z;
    bank_register <= f.bb;
    superbank_bit <= f.sb;
    memory_word <= f.word;
    extracode <= f.xc;
    substitute <= f.sub;
    index_value <= f.idx;
    do @(posedge clk); while (!in_ready);
    pending_decodes.push_back(want);
    words_sent++;
  endtask

  int ready_pct = 100;
  int rx_cycle = 0;
  int rx_hold = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_cycle <= 0;
      rx_hold <= 0;
      hold_done <= 1'b0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!hold_done && words_sent >= HOLD_AFTER) begin
      out_ready <= 1'b0;
      rx_hold <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 48 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 80;
          2: ready_pct <= 45;
          default: ready_pct <= 15;
        endcase
      end
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  always @(posedge clk) begin
    decode_t got;
    decode_t want;
    if (!rst && out_valid && out_ready) begin
      got = mk_decode(location_is_fixed, bank, offset, shown_word, prefix_t'(prefix),
                      mnemonic_t'(mnemonic), operand, has_operand);
      if (pending_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected: mn=%0d op=%0o",
                   $realtime, got.mn, got.operand);
      end else begin
        want = pending_decodes.pop_front();
        if (got.fixed !== want.fixed || got.bank !== want.bank ||
            got.offset !== want.offset || got.word !== want.word ||
            got.pfx !== want.pfx || got.mn !== want.mn ||
            got.operand !== want.operand || got.has_op !== want.has_op) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp fixed=%0d bank=%0d off=%0o word=%0o",
                     $realtime, want.fixed, want.bank, want.offset, want.word,
                     " pfx=%0d mn=%0d op=%0o has=%0d",
                     want.pfx, want.mn, want.operand, want.has_op,
                     " | got fixed=%0d bank=%0d off=%0o word=%0o",
                     got.fixed, got.bank, got.offset, got.word,
                     " pfx=%0d mn=%0d op=%0o has=%0d",
                     got.pfx, got.mn, got.operand, got.has_op);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("banked_address_and_opcode_decoder test failed");
    $finish;
  end

  initial begin
    fetch_t f;
    int     n;
    add_vector(mk_fetch(12'd0, 15'd0, 1'b0, 15'd0, 1'b0, 1'b0, 15'd0), 1'b1,
               mk_decode(1'b0, 6'd0, 10'd0, 15'd0, PFX_NONE, MN_XXALQ, 12'd0, 1'b0));
    add_vector(mk_fetch(12'hFFF, 15'h7FFF, 1'b1, 15'h7FFF, 1'b1, 1'b0, 15'd0), 1'b1,
               mk_decode(1'b1, 6'd3, 10'h3FF, 15'h7FFF, PFX_NONE, MN_MP, 12'hFFF, 1'b1));
    add_vector(mk_fetch(ADDR_SWITCHED_E, 15'o7, 1'b0, WORD_NOOP_E, 1'b0, 1'b0, 15'd0), 1'b1,
               mk_decode(1'b0, 6'd7, 10'd0, WORD_NOOP_E, PFX_NONE, MN_NOOP, 12'd0, 1'b0));
    add_vector(mk_fetch(ADDR_SWITCHED_F, 15'h7C00, 1'b1, 15'o2001, 1'b0, 1'b0, 15'd0), 1'b1,
               mk_decode(1'b1, 6'd39, 10'd0, 15'o2001, PFX_NONE, MN_NOOP, 12'd0, 1'b0));
    add_vector(mk_fetch(12'o100, WORD_COM, 1'b0, 15'o12345, 1'b0, 1'b1, 15'd0), 1'b1,
               mk_decode(1'b0, 6'd0, 10'o100, 15'o12345, PFX_SUBST, MN_COM, 12'd0, 1'b0));
    add_vector(mk_fetch(12'hFFF, 15'd0, 1'b0, 15'o10000, 1'b0, 1'b0, 15'd0), 1'b1,
               mk_decode(1'b1, 6'd3, 10'h3FF, 15'o10000, PFX_NONE, MN_NOOP, 12'd0, 1'b0));
    add_vector(mk_fetch(12'o3777, 15'h7C00, 1'b0, WORD_NO_NOOP, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o1377, 15'h3, 1'b0, WORD_NOOP_E, 1'b0, 1'b0, 15'o5), 1'b0, '0);
    add_vector(mk_fetch(ADDR_SWITCHED_F, 15'h6000, 1'b1, 15'd0, 1'b0, 1'b0, 15'o77776),
               1'b0, '0);
    add_vector(mk_fetch(ADDR_FIXED_FIXED, 15'd0, 1'b0, WORD_EXTEND, 1'b0, 1'b0, 15'o77777),
               1'b0, '0);
    add_vector(mk_fetch(12'o200, 15'o12345, 1'b0, WORD_DDOUBL, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o1500, 15'o54321, 1'b1, WORD_DOUBLE, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o2400, 15'o33333, 1'b0, WORD_DTCB, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o5000, 15'o44444, 1'b1, WORD_DTCF, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o7000, 15'o11111, 1'b0, WORD_INHINT, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o3000, 15'o70000, 1'b1, WORD_OVSK, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o1000, 15'o22222, 1'b0, WORD_RELINT, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o6000, 15'o66666, 1'b0, WORD_RESUME, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o0377, 15'o55555, 1'b1, WORD_RETURN, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o4444, 15'o12121, 1'b0, WORD_TCAA, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o1600, 15'o21212, 1'b0, WORD_XLQ, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o3500, 15'o34343, 1'b1, WORD_ZL, 1'b0, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o0600, 15'o43434, 1'b0, WORD_DCOM, 1'b1, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o7777, 15'o56565, 1'b1, WORD_SQUARE, 1'b1, 1'b0, 15'd0), 1'b0, '0);
    add_vector(mk_fetch(12'o2222, 15'o65656, 1'b0, WORD_ZQ, 1'b1, 1'b0, 15'd0), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i])
      offer_word(stim_table[i].stim,
                 stim_table[i].typed ? stim_table[i].want
                                     : resolve_and_decode(stim_table[i].stim));
    repeat (RANDOM_WORDS) begin
      f = random_fetch();
      offer_word(f, resolve_and_decode(f));
    end
    in_valid <= 1'b0;

    n = 0;
    while (pending_decodes.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("banked_address_and_opcode_decoder test passed");
    end else begin
      $display("banked_address_and_opcode_decoder test failed");
    end
    $finish;
  end

endmodule
